/* design/sps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the smallest prime factor sieve
// Holds the number range, prime list size and the request structures that
// travel between the build controller, the memories and the top level.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Largest number the factor table can cover, and its word width.
    localparam int NUM_W       = 16;
    localparam int MAX_NUMBER  = 65535;
    localparam int FT_DEPTH    = MAX_NUMBER + 1;

    // Capacity of the prime list and the width of its index and count.
    localparam int MAX_PRIMES  = 6542;
    localparam int PC_W        = 13;

    // Width of the build loop's number counter (one above the largest number).
    localparam int IDX_W       = NUM_W + 1;

    // Width of a product of a prime and a number.
    localparam int PROD_W      = 2 * NUM_W;

    localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(MAX_NUMBER);

    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [PC_W-1:0]   pidx_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Access request to the factor table.
    typedef struct packed {
        logic we;
        num_t waddr;
        num_t wdata;
        logic re;
        num_t raddr;
    } ft_req_t;

    // Access request to the prime list.
    typedef struct packed {
        logic  we;
        pidx_t waddr;
        num_t  wdata;
        logic  re;
        pidx_t raddr;
    } pl_req_t;

    // Status of the build controller.
    typedef struct packed {
        logic busy;
        logic done;
    } bld_stat_t;

endpackage
`default_nettype wire

/* design/sps_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sps_ram: simple dual-port synchronous RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module sps_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* design/sps_builder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sps_builder: linear sieve build controller
// Clears the factor table up to the limit, then walks every number, records
// new primes and marks the products with listed primes up to its own factor.
// ----------------------------------------------------------------------------
module sps_builder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire sps_pkg::num_t       top,
    input  wire sps_pkg::num_t       ft_rdata,
    input  wire sps_pkg::num_t       pl_rdata,
    output sps_pkg::ft_req_t         ft_req,
    output sps_pkg::pl_req_t         pl_req,
    output sps_pkg::bld_stat_t       stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_PREAD = 3'd4;
    localparam logic [2:0] S_PMUL  = 3'd5;
    localparam logic [2:0] S_PMARK = 3'd6;

    logic [2:0]     state_reg, state_next;
    sps_pkg::idx_t  i_reg, i_next;
    sps_pkg::pidx_t count_reg, count_next;
    sps_pkg::pidx_t k_reg, k_next;
    sps_pkg::num_t  f_reg, f_next;
    sps_pkg::num_t  p_reg, p_next;
    sps_pkg::prod_t prod_reg, prod_next;
    sps_pkg::idx_t  top_ext;

    assign top_ext = {1'b0, top};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg    <= f_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        count_next = count_reg;
        k_next     = k_reg;
        f_next     = f_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        ft_req     = '0;
        pl_req     = '0;
        stat.busy  = (state_reg != S_IDLE);
        stat.done  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    count_next = '0;
                    k_next     = '0;
                    state_next = S_CLEAR;
                end
            end

            // Clear entries zero to the limit; the entry for one holds 1.
            S_CLEAR:
            begin
                ft_req.we    = 1'b1;
                ft_req.waddr = i_reg[sps_pkg::NUM_W-1:0];
                ft_req.wdata = (i_reg == sps_pkg::idx_t'(1)) ? sps_pkg::num_t'(1) : '0;
                if (i_reg == top_ext)
                begin
                    i_next     = sps_pkg::idx_t'(2);
                    state_next = S_FETCH;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end

            S_FETCH:
            begin
                if (i_reg > top_ext)
                begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ft_req.re    = 1'b1;
                    ft_req.raddr = i_reg[sps_pkg::NUM_W-1:0];
                    state_next   = S_CHECK;
                end
            end

            // An empty entry means a new prime: it is its own factor.
            S_CHECK:
            begin
                k_next = '0;
                if (ft_rdata == '0)
                begin
                    ft_req.we    = 1'b1;
                    ft_req.waddr = i_reg[sps_pkg::NUM_W-1:0];
                    ft_req.wdata = i_reg[sps_pkg::NUM_W-1:0];
                    f_next       = i_reg[sps_pkg::NUM_W-1:0];
                    if (count_reg < sps_pkg::pidx_t'(sps_pkg::MAX_PRIMES))
                    begin
                        pl_req.we    = 1'b1;
                        pl_req.waddr = count_reg;
                        pl_req.wdata = i_reg[sps_pkg::NUM_W-1:0];
                        count_next   = count_reg + 1'b1;
                    end
                end
                else
                begin
                    f_next = ft_rdata;
                end
                state_next = S_PREAD;
            end

            S_PREAD:
            begin
                if (k_reg == count_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    pl_req.re    = 1'b1;
                    pl_req.raddr = k_reg;
                    state_next   = S_PMUL;
                end
            end

            S_PMUL:
            begin
                p_next     = pl_rdata;
                prod_next  = sps_pkg::prod_t'(pl_rdata) *
                             sps_pkg::prod_t'(i_reg[sps_pkg::NUM_W-1:0]);
                state_next = S_PMARK;
            end

            // Stop at the first prime above the factor or a product past the limit.
            S_PMARK:
            begin
                if ((prod_reg > sps_pkg::prod_t'(top)) || (p_reg > f_reg))
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    ft_req.we    = 1'b1;
                    ft_req.waddr = prod_reg[sps_pkg::NUM_W-1:0];
                    ft_req.wdata = p_reg;
                    k_next       = k_reg + 1'b1;
                    state_next   = S_PREAD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_mark_above_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PMARK && ft_req.we) |-> (prod_reg > sps_pkg::prod_t'(i_reg)))
        else $error("sieve marks a product not above the current number");

    a_pl_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pl_req.we |-> (pl_req.waddr < sps_pkg::pidx_t'(sps_pkg::MAX_PRIMES)))
        else $error("prime list written beyond its capacity");

    a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= count_reg)
        else $error("prime index ran past the prime count");
`endif

endmodule
`default_nettype wire

/* design/smallest_prime_factor_sieve.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve: smallest prime factor lookup
// Answers each number with its smallest prime factor, a prime flag and an
// out-of-range flag from a table that a linear sieve builds on demand.
// ----------------------------------------------------------------------------
// The first number offered after reset or after a write of limit starts a
// table build, and in_ready stays low until it finishes. The build first
// clears the factor table from zero to the limit, one entry a cycle, and
// then walks every number from two to the limit: it reads and classifies
// the number, then for each listed prime reads the prime, forms the
// product and marks it, until a prime above the number's factor, a product
// past the limit or the end of the prime list ends the run. A linear sieve
// marks every composite exactly once, also over the full 16-bit range.
// Once built, the block takes one number per cycle while the output
// register is free or its word is being taken. The table is read at the
// edge that takes the number, and the output register loads the read data
// once it is free. A write to limit is accepted at any cycle, stores the
// limit and marks the table stale; write it while no query is in flight.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve (
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire sps_pkg::num_t limit,

    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire sps_pkg::num_t number,

    output logic               out_valid,
    input  wire logic          out_ready,
    output sps_pkg::num_t      smallest_factor,
    output logic               is_prime,
    output logic               out_of_range
);

    sps_pkg::num_t      limit_reg;
    logic               built_reg;
    logic               s1_valid_reg;
    sps_pkg::num_t      s1_num_reg;
    logic               out_valid_reg;
    sps_pkg::num_t      factor_reg;
    logic               prime_reg;
    logic               oor_reg;

    sps_pkg::ft_req_t   bld_ft_req;
    sps_pkg::ft_req_t   ft_req;
    sps_pkg::pl_req_t   pl_req;
    sps_pkg::bld_stat_t bld_stat;
    sps_pkg::num_t      ft_rdata;
    sps_pkg::num_t      pl_rdata;

    logic               cfg_write;
    logic               accept;
    logic               out_free;
    logic               load_out;
    logic               start;
    logic               oor;

    // The configuration word is always taken; it stores the limit and marks the table for a rebuild.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // The output register frees up when empty or when its word is taken.
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = s1_valid_reg && out_free;

    // Queries flow only over a finished table and while the lookup stage
    // can move on; the read data holds while the lookup stage stalls.
    assign in_ready = built_reg && !bld_stat.busy && (!s1_valid_reg || out_free);
    assign accept   = in_valid && in_ready;
    assign start    = in_valid && !built_reg && !bld_stat.busy;

    // The builder owns the factor table port while it runs.
    always_comb
    begin
        if (bld_stat.busy)
        begin
            ft_req = bld_ft_req;
        end
        else
        begin
            ft_req       = '0;
            ft_req.re    = accept;
            ft_req.raddr = number;
        end
    end

    sps_builder u_builder (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .top      (limit_reg),
        .ft_rdata (ft_rdata),
        .pl_rdata (pl_rdata),
        .ft_req   (bld_ft_req),
        .pl_req   (pl_req),
        .stat     (bld_stat)
    );

    sps_ram #(
        .WIDTH  (sps_pkg::NUM_W),
        .DEPTH  (sps_pkg::FT_DEPTH),
        .ADDR_W (sps_pkg::NUM_W)
    ) u_factor_table (
        .clk   (clk),
        .we    (ft_req.we),
        .waddr (ft_req.waddr),
        .wdata (ft_req.wdata),
        .re    (ft_req.re),
        .raddr (ft_req.raddr),
        .rdata (ft_rdata)
    );

    sps_ram #(
        .WIDTH  (sps_pkg::NUM_W),
        .DEPTH  (sps_pkg::MAX_PRIMES),
        .ADDR_W (sps_pkg::PC_W)
    ) u_prime_list (
        .clk   (clk),
        .we    (pl_req.we),
        .waddr (pl_req.waddr),
        .wdata (pl_req.wdata),
        .re    (pl_req.re),
        .raddr (pl_req.raddr),
        .rdata (pl_rdata)
    );

    // Zero, or a number above the limit, is outside the table.
    assign oor = (s1_num_reg == '0) || (s1_num_reg > limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= sps_pkg::LIMIT_RESET;
            built_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= limit;
                built_reg <= 1'b0;
            end
            else if (bld_stat.done)
            begin
                built_reg <= 1'b1;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (load_out)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_num_reg <= number;
        end
        if (load_out)
        begin
            factor_reg <= oor ? '0 : ft_rdata;
            prime_reg  <= !oor && (s1_num_reg >= sps_pkg::num_t'(2)) &&
                          (ft_rdata == s1_num_reg);
            oor_reg    <= oor;
        end
    end

    assign out_valid       = out_valid_reg;
    assign smallest_factor = factor_reg;
    assign is_prime        = prime_reg;
    assign out_of_range    = oor_reg;

`ifndef SYNTHESIS
    a_ready_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> built_reg)
        else $error("query taken over a stale factor table");

    a_no_query_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        bld_stat.busy |-> (!in_ready && !s1_valid_reg))
        else $error("query overlaps a table build");

    a_oor_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (smallest_factor == '0 && !is_prime))
        else $error("out-of-range word carries a factor or prime flag");
`endif

endmodule
`default_nettype wire

/* verif/tb_smallest_prime_factor_sieve.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smallest_prime_factor_sieve: self-checking bench for the factor sieve
// Queries numbers under several limit settings, including the full 16-bit
// range, and compares every result word with a sieve computed in the bench.
// ----------------------------------------------------------------------------
module tb_smallest_prime_factor_sieve;

    // The scoreboard keeps its own copy of the limit and of the factor table.
    // The table is rebuilt on the first query after a limit write, as the
    // block does, so each accepted query turns into exactly one expected word.
    class factor_scoreboard;

        typedef struct packed {
            sps_pkg::num_t factor;
            logic          prime;
            logic          oor;
        } answer_t;

        sps_pkg::num_t factor_tbl[sps_pkg::FT_DEPTH];
        sps_pkg::num_t primes[sps_pkg::MAX_PRIMES];
        int unsigned   n_primes;
        bit            built;
        sps_pkg::num_t lim;
        answer_t       answers_due[$];
        int unsigned   n_queries;
        int unsigned   n_checked;
        int unsigned   n_errors;

        function new();
            lim       = sps_pkg::LIMIT_RESET;
            built     = 1'b0;
            n_primes  = 0;
            n_queries = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void set_limit(sps_pkg::num_t v);
            lim   = v;
            built = 1'b0;
        endfunction

        // Linear sieve: every composite is marked once, by its smallest prime.
        function void rebuild_factors();
            int unsigned top;
            int unsigned p;
            int unsigned m;
            top = lim;
            for (int unsigned j = 0; j < sps_pkg::FT_DEPTH; j++)
            begin
                factor_tbl[j] = '0;
            end
            n_primes = 0;
            if (top >= 1)
            begin
                factor_tbl[1] = sps_pkg::num_t'(1);
            end
            for (int unsigned i = 2; i <= top; i++)
            begin
                if (factor_tbl[i] == 0)
                begin
                    factor_tbl[i] = sps_pkg::num_t'(i);
                    if (n_primes < sps_pkg::MAX_PRIMES)
                    begin
                        primes[n_primes] = sps_pkg::num_t'(i);
                        n_primes++;
                    end
                end
                for (int unsigned k = 0; k < n_primes; k++)
                begin
                    p = primes[k];
                    m = p * i;
                    if (m > top || p > factor_tbl[i])
                    begin
                        break;
                    end
                    factor_tbl[m] = sps_pkg::num_t'(p);
                end
            end
            built = 1'b1;
        endfunction

        function void note_query(sps_pkg::num_t n);
            answer_t a;
            if (!built)
            begin
                rebuild_factors();
            end
            if (n == 0 || n > lim)
            begin
                a.factor = '0;
                a.prime  = 1'b0;
                a.oor    = 1'b1;
            end
            else
            begin
                a.factor = factor_tbl[n];
                a.prime  = (n >= 2 && factor_tbl[n] == n);
                a.oor    = 1'b0;
            end
            answers_due = {answers_due, a};
            n_queries++;
        endfunction

        function void note_error(string msg);
            n_errors++;
            if (n_errors <= 10)
            begin
                $display("ERROR @%0t: %s", $realtime, msg);
            end
        endfunction

        function void check_answer(sps_pkg::num_t f, logic p, logic o);
            answer_t a;
            n_checked++;
            if (answers_due.size() == 0)
            begin
                note_error($sformatf("result word f=%0d p=%0b o=%0b with no query pending",
                                     f, p, o));
                return;
            end
            a = answers_due.pop_front();
            if (f !== a.factor || p !== a.prime || o !== a.oor)
            begin
                note_error($sformatf("expected f=%0d p=%0b o=%0b, got f=%0d p=%0b o=%0b",
                                     a.factor, a.prime, a.oor, f, p, o));
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

    endclass

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // A full 16-bit build takes no query and gives no result while it runs, and the
    // bench writes no limit meanwhile, so the watchdog limit must cover a whole build.
    localparam int STALL_LIMIT   = 3_000_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;

    // Random phases: limit range, number of queries and idling pattern.
    localparam int         N_PHASES        = 6;
    localparam int         PRESSURE_PHASE  = 2;
    localparam int         PH_LO[N_PHASES]  = '{2, 100, 1000, 10, 2, 4000};
    localparam int         PH_HI[N_PHASES]  = '{60, 999, 4000, 10, 4000, 8191};
    localparam int         PH_CNT[N_PHASES] = '{50, 60, 60, 40, 60, 50};
    localparam idle_mode_t PH_IDLE[N_PHASES] =
        '{IDLE_SENDER, IDLE_RECEIVER, IDLE_NONE, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    sps_pkg::num_t limit     = '0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    sps_pkg::num_t number    = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    sps_pkg::num_t smallest_factor;
    logic          is_prime;
    logic          out_of_range;

    factor_scoreboard sb;

    // Current limit as the bench sees it, used to aim the random numbers.
    int unsigned cur_limit      = 65535;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_off       = 1'b0;
    int          n_settings     = 1;
    int          stall_cycles   = 0;

    smallest_prime_factor_sieve dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .limit           (limit),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .number          (number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .smallest_factor (smallest_factor),
        .is_prime        (is_prime),
        .out_of_range    (out_of_range)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side. Outputs are sampled at the edge, before the block's own
    // updates land, and ready for the next edge is chosen at random unless
    // a long hold-off is in force.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_answer(smallest_factor, is_prime, out_of_range);
        end
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer.", stall_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic set_idle(input idle_mode_t m);
        case (m)
            IDLE_NONE:
            begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  <= 61;
                recv_stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 61;
            end
            default:
            begin
                send_idle_pct  <= 14;
                recv_stall_pct <= 14;
            end
        endcase
    endtask

    // Offers one query word and returns at the edge that accepts it. Valid
    // stays high from one word to the next when no gap is drawn.
    task automatic push_number(input sps_pkg::num_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_query(v);
    endtask

    task automatic query_each(input sps_pkg::num_t vals[$]);
        foreach (vals[i])
        begin
            push_number(vals[i]);
        end
        in_valid <= 1'b0;
    endtask

    // Most numbers fall inside the table, some right at its edge, and the
    // rest anywhere in the 16-bit range so that every bit toggles.
    function automatic sps_pkg::num_t pick_number();
        int r;
        r = $urandom_range(99);
        if (r < 70 && cur_limit >= 1)
        begin
            return sps_pkg::num_t'($urandom_range(cur_limit, 1));
        end
        else if (r < 85)
        begin
            return sps_pkg::num_t'(cur_limit + $urandom_range(2) - 1);
        end
        return sps_pkg::num_t'($urandom);
    endfunction

    task automatic run_queries(input int count);
        repeat (count)
        begin
            push_number(pick_number());
        end
        in_valid <= 1'b0;
    endtask

    // Waits until every expected word has come back, then a few more cycles
    // so that the block is idle before the limit changes.
    task automatic drain();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input sps_pkg::num_t v);
        cfg_valid <= 1'b1;
        limit     <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_limit(v);
        cur_limit = v;
        n_settings++;
    endtask

    initial
    begin
        sps_pkg::num_t corner_set[$];
        sps_pkg::num_t low_set[$];
        int            leftover;
        int            failures;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full range from the reset value of limit: zero, one, the smallest
        // primes and composites, squares of primes, a power of two, a product
        // of two large primes, the largest 16-bit prime and the top values.
        set_idle(IDLE_NONE);
        corner_set = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd49, 16'd97,
                       16'd32768, 16'd64507, 16'd65521, 16'd65534, 16'd65535};
        query_each(corner_set);
        drain();
        set_idle(IDLE_BOTH);
        run_queries(110);
        drain();

        // Limit zero leaves everything out of range.
        write_limit(sps_pkg::num_t'(0));
        set_idle(IDLE_NONE);
        low_set = '{16'd0, 16'd1, 16'd65535};
        query_each(low_set);
        drain();

        // Limit one covers only the number one.
        write_limit(sps_pkg::num_t'(1));
        low_set = '{16'd0, 16'd1, 16'd2};
        query_each(low_set);
        drain();

        // Smallest regular limit, then the same value written again, which
        // must still force a rebuild.
        write_limit(sps_pkg::num_t'(2));
        low_set = '{16'd0, 16'd1, 16'd2, 16'd3};
        query_each(low_set);
        drain();
        write_limit(sps_pkg::num_t'(2));
        low_set = '{16'd2, 16'd3};
        query_each(low_set);
        drain();

        // Random phases with mostly small limits to keep builds short.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_limit(sps_pkg::num_t'($urandom_range(PH_HI[ph], PH_LO[ph])));
            set_idle(PH_IDLE[ph]);
            if (ph == PRESSURE_PHASE)
            begin
                // The receiver holds off from the start of this phase until a long
                // stretch after its first word is taken, so the block backs up and
                // drops in_ready while the sender keeps offering.
                fork
                    run_queries(PH_CNT[ph]);
                    begin
                        hold_off <= 1'b1;
                        do
                            @(posedge clk);
                        while (!(in_valid && in_ready));
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join
            end
            else
            begin
                run_queries(PH_CNT[ph]);
            end
            drain();
        end

        leftover = sb.pending();
        failures = sb.n_errors + leftover;
        if (leftover != 0)
        begin
            $display("ERROR: %0d expected result words never arrived.", leftover);
        end
        $display("Run covered %0d queries and %0d result words over %0d limit settings,",
                 sb.n_queries, sb.n_checked, n_settings);
        $display("from limit zero up to the full 16-bit range, with idling and back-pressure.");
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/sps_pkg.sv
design/sps_ram.sv
design/sps_builder.sv
design/smallest_prime_factor_sieve.sv
verif/tb_smallest_prime_factor_sieve.sv
